// ===== rtl/core/i2cm_pkg.sv =====
package i2cm_pkg;

  localparam int unsigned BYTE_W = 8;
  localparam int unsigned TIMER_W = 8;
  localparam int unsigned BITCNT_W = 4;
  localparam int unsigned CMD_W = 3;
  localparam int unsigned CFG_IDX_W = 2;
  localparam int unsigned STEP_W = 5;

  localparam logic [BYTE_W-1:0] BIT_PHASE_RST = 8'd2;
  localparam logic [BYTE_W-1:0] EDGE_HOLD_RST = 8'd4;
  localparam logic [BYTE_W-1:0] ACK_TIMEOUT_RST = 8'd50;
  localparam logic [BITCNT_W-1:0] BITS_PER_BYTE = 4'd8;

  localparam int unsigned QUEUE_DEPTH = 2;
  localparam int unsigned QUEUE_PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int unsigned QUEUE_CNT_W = $clog2(QUEUE_DEPTH + 1);

  typedef enum logic [CMD_W-1:0] {
    CMD_TICK     = 3'd0,
    CMD_START    = 3'd1,
    CMD_STOP     = 3'd2,
    CMD_SEND     = 3'd3,
    CMD_WAIT_ACK = 3'd4,
    CMD_READ     = 3'd5
  } cmd_e;

  typedef enum logic [1:0] {
    KIND_NONE = 2'd0,
    KIND_TICK = 2'd1,
    KIND_CMD  = 2'd2
  } kind_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_BIT_PHASE   = 2'd0,
    CFG_EDGE_HOLD   = 2'd1,
    CFG_ACK_TIMEOUT = 2'd2
  } cfg_e;

  typedef enum logic [STEP_W-1:0] {
    ST_IDLE    = 5'd0,
    ST_START_A = 5'd1,
    ST_START_B = 5'd2,
    ST_STOP_A  = 5'd3,
    ST_STOP_B  = 5'd4,
    ST_TX_LOW  = 5'd5,
    ST_TX_HIGH = 5'd6,
    ST_TX_TAIL = 5'd7,
    ST_AK_PRE  = 5'd8,
    ST_AK_POLL = 5'd9,
    ST_RD_LOW  = 5'd10,
    ST_RD_HIGH = 5'd11,
    ST_RD_AL   = 5'd12,
    ST_RD_AH   = 5'd13
  } step_e;

  typedef struct packed {
    logic [CMD_W-1:0]  command;
    logic [BYTE_W-1:0] tx_byte;
    logic              send_ack;
    logic              sda_in;
  } in_item_t;

  typedef struct packed {
    logic              scl_level;
    logic              sda_level;
    logic              sda_is_output;
    logic              busy_res;
    logic              op_done;
    logic [BYTE_W-1:0] rx_byte;
    logic              ack_failed;
    logic              cmd_rejected;
  } out_item_t;

  typedef struct packed {
    kind_e             kind;
    cmd_e              cmd;
    logic [BYTE_W-1:0] tx_byte;
    logic              send_ack;
    logic              sda_in;
  } op_t;

  typedef struct packed {
    logic valid;
    op_t  op;
  } queue_head_t;

endpackage

// ===== rtl/core/i2cm_front.sv =====
module i2cm_front (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  input  i2cm_pkg::in_item_t   in_item_i,
  input  logic                 pop_i,
  output i2cm_pkg::queue_head_t head_o
);

  i2cm_pkg::op_t                           op_d;
  i2cm_pkg::op_t                           mem_q [i2cm_pkg::QUEUE_DEPTH];
  logic [i2cm_pkg::QUEUE_PTR_W-1:0]        wr_ptr_q, wr_ptr_d;
  logic [i2cm_pkg::QUEUE_PTR_W-1:0]        rd_ptr_q, rd_ptr_d;
  logic [i2cm_pkg::QUEUE_CNT_W-1:0]        cnt_q, cnt_d;
  logic                                    push;
  logic                                    pop;

  // classify the incoming item
  always_comb begin
    op_d.kind     = i2cm_pkg::KIND_NONE;
    op_d.cmd      = i2cm_pkg::CMD_TICK;
    op_d.tx_byte  = in_item_i.tx_byte;
    op_d.send_ack = in_item_i.send_ack;
    op_d.sda_in   = in_item_i.sda_in;
    case (in_item_i.command)
      i2cm_pkg::CMD_TICK: begin
        op_d.kind = i2cm_pkg::KIND_TICK;
      end
      i2cm_pkg::CMD_START, i2cm_pkg::CMD_STOP, i2cm_pkg::CMD_SEND,
      i2cm_pkg::CMD_WAIT_ACK, i2cm_pkg::CMD_READ: begin
        op_d.kind = i2cm_pkg::KIND_CMD;
        op_d.cmd  = i2cm_pkg::cmd_e'(in_item_i.command);
      end
      default: begin
        op_d.kind = i2cm_pkg::KIND_NONE;
      end
    endcase
  end

  assign in_stall_o   = (cnt_q == i2cm_pkg::QUEUE_CNT_W'(i2cm_pkg::QUEUE_DEPTH));
  assign push         = in_valid_i && !in_stall_o;
  assign head_o.valid = (cnt_q != '0);
  assign head_o.op    = mem_q[rd_ptr_q];
  assign pop          = pop_i && head_o.valid;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (push) begin
      if (wr_ptr_q == i2cm_pkg::QUEUE_PTR_W'(i2cm_pkg::QUEUE_DEPTH - 1)) begin
        wr_ptr_d = '0;
      end else begin
        wr_ptr_d = wr_ptr_q + 1'b1;
      end
    end
    if (pop) begin
      if (rd_ptr_q == i2cm_pkg::QUEUE_PTR_W'(i2cm_pkg::QUEUE_DEPTH - 1)) begin
        rd_ptr_d = '0;
      end else begin
        rd_ptr_d = rd_ptr_q + 1'b1;
      end
    end
    if (push && !pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (pop && !push) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_ptr_q] <= op_d;
    end
  end

endmodule

// ===== rtl/core/i2cm_back.sv =====
module i2cm_back (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_we_i,
  input  logic [i2cm_pkg::CFG_IDX_W-1:0]    cfg_idx_i,
  input  logic [i2cm_pkg::BYTE_W-1:0]       cfg_wdata_i,
  input  i2cm_pkg::queue_head_t             head_i,
  output logic                              pop_o,
  output logic                              out_valid_o,
  input  logic                              out_stall_i,
  output i2cm_pkg::out_item_t               out_item_o
);

  logic [i2cm_pkg::BYTE_W-1:0]   bit_phase_q, edge_hold_q, ack_timeout_q;
  i2cm_pkg::step_e               step_q, step_d;
  logic [i2cm_pkg::TIMER_W-1:0]  timer_q, timer_d;
  logic [i2cm_pkg::BITCNT_W-1:0] bit_cnt_q, bit_cnt_d, bit_cnt_inc;
  logic [i2cm_pkg::BYTE_W-1:0]   shift_q, shift_d;
  logic [i2cm_pkg::BYTE_W-1:0]   poll_cnt_q, poll_cnt_d;
  logic                          ack_choice_q, ack_choice_d;
  logic                          fail_pend_q, fail_pend_d;
  logic                          scl_q, scl_d;
  logic                          sda_q, sda_d;
  logic                          drive_q, drive_d;
  logic                          done, failed, rejected;
  logic [i2cm_pkg::BYTE_W-1:0]   rx;
  logic                          out_valid_q, out_valid_d;
  i2cm_pkg::out_item_t           out_item_q, out_item_d;
  i2cm_pkg::op_t                 op;

  assign op          = head_i.op;
  assign pop_o       = head_i.valid && (!out_valid_q || !out_stall_i);
  assign bit_cnt_inc = bit_cnt_q + 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bit_phase_q   <= i2cm_pkg::BIT_PHASE_RST;
      edge_hold_q   <= i2cm_pkg::EDGE_HOLD_RST;
      ack_timeout_q <= i2cm_pkg::ACK_TIMEOUT_RST;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        i2cm_pkg::CFG_BIT_PHASE:   bit_phase_q   <= cfg_wdata_i;
        i2cm_pkg::CFG_EDGE_HOLD:   edge_hold_q   <= cfg_wdata_i;
        i2cm_pkg::CFG_ACK_TIMEOUT: ack_timeout_q <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  always_comb begin
    step_d       = step_q;
    timer_d      = timer_q;
    bit_cnt_d    = bit_cnt_q;
    shift_d      = shift_q;
    poll_cnt_d   = poll_cnt_q;
    ack_choice_d = ack_choice_q;
    fail_pend_d  = fail_pend_q;
    scl_d        = scl_q;
    sda_d        = sda_q;
    drive_d      = drive_q;
    done         = 1'b0;
    failed       = 1'b0;
    rejected     = 1'b0;
    rx           = '0;
    if (pop_o) begin
      case (op.kind)
        i2cm_pkg::KIND_CMD: begin
          if (step_q != i2cm_pkg::ST_IDLE) begin
            rejected = 1'b1;
          end else begin
            case (op.cmd)
              i2cm_pkg::CMD_START: begin
                drive_d = 1'b1;
                sda_d   = 1'b1;
                scl_d   = 1'b1;
                step_d  = i2cm_pkg::ST_START_A;
                timer_d = edge_hold_q;
              end
              i2cm_pkg::CMD_STOP: begin
                fail_pend_d = 1'b0;
                drive_d     = 1'b1;
                scl_d       = 1'b0;
                sda_d       = 1'b0;
                step_d      = i2cm_pkg::ST_STOP_A;
                timer_d     = edge_hold_q;
              end
              i2cm_pkg::CMD_SEND: begin
                drive_d   = 1'b1;
                scl_d     = 1'b0;
                sda_d     = op.tx_byte[i2cm_pkg::BYTE_W-1];
                shift_d   = {op.tx_byte[i2cm_pkg::BYTE_W-2:0], 1'b0};
                bit_cnt_d = '0;
                step_d    = i2cm_pkg::ST_TX_LOW;
                timer_d   = bit_phase_q;
              end
              i2cm_pkg::CMD_WAIT_ACK: begin
                drive_d     = 1'b0;
                sda_d       = 1'b1;
                fail_pend_d = 1'b0;
                step_d      = i2cm_pkg::ST_AK_PRE;
                timer_d     = i2cm_pkg::TIMER_W'(1);
              end
              i2cm_pkg::CMD_READ: begin
                drive_d      = 1'b0;
                scl_d        = 1'b0;
                shift_d      = '0;
                bit_cnt_d    = '0;
                ack_choice_d = op.send_ack;
                step_d       = i2cm_pkg::ST_RD_LOW;
                timer_d      = bit_phase_q;
              end
              default: ;
            endcase
          end
        end
        i2cm_pkg::KIND_TICK: begin
          if (step_q == i2cm_pkg::ST_IDLE) begin
            step_d = step_q;
          end else if (step_q == i2cm_pkg::ST_AK_POLL) begin
            if (!op.sda_in) begin
              scl_d  = 1'b0;
              step_d = i2cm_pkg::ST_IDLE;
              done   = 1'b1;
            end else if (poll_cnt_q >= ack_timeout_q) begin
              fail_pend_d = 1'b1;
              drive_d     = 1'b1;
              scl_d       = 1'b0;
              sda_d       = 1'b0;
              step_d      = i2cm_pkg::ST_STOP_A;
              timer_d     = edge_hold_q;
            end else begin
              poll_cnt_d = poll_cnt_q + 1'b1;
            end
          end else if (timer_q > i2cm_pkg::TIMER_W'(1)) begin
            timer_d = timer_q - 1'b1;
          end else begin
            timer_d = '0;
            case (step_q)
              i2cm_pkg::ST_START_A: begin
                sda_d   = 1'b0;
                step_d  = i2cm_pkg::ST_START_B;
                timer_d = edge_hold_q;
              end
              i2cm_pkg::ST_START_B: begin
                scl_d  = 1'b0;
                step_d = i2cm_pkg::ST_IDLE;
                done   = 1'b1;
              end
              i2cm_pkg::ST_STOP_A: begin
                scl_d   = 1'b1;
                sda_d   = 1'b1;
                step_d  = i2cm_pkg::ST_STOP_B;
                timer_d = edge_hold_q;
              end
              i2cm_pkg::ST_STOP_B: begin
                step_d      = i2cm_pkg::ST_IDLE;
                done        = 1'b1;
                failed      = fail_pend_q;
                fail_pend_d = 1'b0;
              end
              i2cm_pkg::ST_TX_LOW: begin
                scl_d   = 1'b1;
                step_d  = i2cm_pkg::ST_TX_HIGH;
                timer_d = bit_phase_q;
              end
              i2cm_pkg::ST_TX_HIGH: begin
                scl_d   = 1'b0;
                step_d  = i2cm_pkg::ST_TX_TAIL;
                timer_d = bit_phase_q;
              end
              i2cm_pkg::ST_TX_TAIL: begin
                bit_cnt_d = bit_cnt_inc;
                if (bit_cnt_inc >= i2cm_pkg::BITS_PER_BYTE) begin
                  step_d = i2cm_pkg::ST_IDLE;
                  done   = 1'b1;
                end else begin
                  sda_d   = shift_q[i2cm_pkg::BYTE_W-1];
                  shift_d = {shift_q[i2cm_pkg::BYTE_W-2:0], 1'b0};
                  step_d  = i2cm_pkg::ST_TX_LOW;
                  timer_d = bit_phase_q;
                end
              end
              i2cm_pkg::ST_AK_PRE: begin
                scl_d      = 1'b1;
                poll_cnt_d = '0;
                step_d     = i2cm_pkg::ST_AK_POLL;
              end
              i2cm_pkg::ST_RD_LOW: begin
                scl_d   = 1'b1;
                shift_d = {shift_q[i2cm_pkg::BYTE_W-2:0], op.sda_in};
                step_d  = i2cm_pkg::ST_RD_HIGH;
                timer_d = bit_phase_q;
              end
              i2cm_pkg::ST_RD_HIGH: begin
                bit_cnt_d = bit_cnt_inc;
                scl_d     = 1'b0;
                timer_d   = bit_phase_q;
                if (bit_cnt_inc >= i2cm_pkg::BITS_PER_BYTE) begin
                  drive_d = 1'b1;
                  sda_d   = !ack_choice_q;
                  step_d  = i2cm_pkg::ST_RD_AL;
                end else begin
                  step_d = i2cm_pkg::ST_RD_LOW;
                end
              end
              i2cm_pkg::ST_RD_AL: begin
                scl_d   = 1'b1;
                step_d  = i2cm_pkg::ST_RD_AH;
                timer_d = bit_phase_q;
              end
              i2cm_pkg::ST_RD_AH: begin
                scl_d  = 1'b0;
                step_d = i2cm_pkg::ST_IDLE;
                done   = 1'b1;
                rx     = shift_q;
              end
              default: begin
                step_d = i2cm_pkg::ST_IDLE;
              end
            endcase
          end
        end
        default: ;
      endcase
    end
  end

  always_comb begin
    out_item_d.scl_level     = scl_d;
    out_item_d.sda_level     = sda_d;
    out_item_d.sda_is_output = drive_d;
    out_item_d.busy_res      = (step_d != i2cm_pkg::ST_IDLE);
    out_item_d.op_done       = done;
    out_item_d.rx_byte       = rx;
    out_item_d.ack_failed    = failed;
    out_item_d.cmd_rejected  = rejected;
    if (pop_o) begin
      out_valid_d = 1'b1;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q       <= i2cm_pkg::ST_IDLE;
      timer_q      <= '0;
      bit_cnt_q    <= '0;
      shift_q      <= '0;
      poll_cnt_q   <= '0;
      ack_choice_q <= 1'b0;
      fail_pend_q  <= 1'b0;
      scl_q        <= 1'b1;
      sda_q        <= 1'b1;
      drive_q      <= 1'b1;
      out_valid_q  <= 1'b0;
    end else begin
      step_q       <= step_d;
      timer_q      <= timer_d;
      bit_cnt_q    <= bit_cnt_d;
      shift_q      <= shift_d;
      poll_cnt_q   <= poll_cnt_d;
      ack_choice_q <= ack_choice_d;
      fail_pend_q  <= fail_pend_d;
      scl_q        <= scl_d;
      sda_q        <= sda_d;
      drive_q      <= drive_d;
      out_valid_q  <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      out_item_q <= out_item_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_item_q;

  a_done_not_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && out_item_q.op_done |-> !out_item_q.busy_res)
    else $error("op_done reported while still busy");

  a_fail_with_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && out_item_q.ack_failed |-> out_item_q.op_done && out_item_q.scl_level)
    else $error("ack failure without completed stop");

  a_reject_keeps_state: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_o && rejected |=> $stable(step_q) && $stable(timer_q))
    else $error("rejected command changed the sequence");

  a_pollwait_released: assert property (@(posedge clk_i) disable iff (!rst_ni)
    step_q == i2cm_pkg::ST_AK_POLL |-> !drive_q && scl_q)
    else $error("ack poll without released sda and high scl");

endmodule

// ===== rtl/core/i2c_master_byte_engine.sv =====
// an accepted item waits in the item queue; its result is then registered at the output
// throughput: one item per cycle while the output is not stalled, set by i2cm_back
// a two-entry item queue sits between the classifier and the sequencer
// reset: asynchronous active low; bus released (scl, sda high, sda driven), sequencer idle,
// queue and output register empty, timing registers back to 2, 4 and 50
module i2c_master_byte_engine (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [i2cm_pkg::CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [i2cm_pkg::BYTE_W-1:0]    cfg_wdata_i,
  input  logic                           in_valid_i,
  output logic                           in_stall_o,
  input  i2cm_pkg::in_item_t             in_item_i,
  output logic                           out_valid_o,
  input  logic                           out_stall_i,
  output i2cm_pkg::out_item_t            out_item_o
);

  i2cm_pkg::queue_head_t head;
  logic                  pop;

  i2cm_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_item_i  (in_item_i),
    .pop_i      (pop),
    .head_o     (head)
  );

  i2cm_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .head_i      (head),
    .pop_o       (pop),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_item_o  (out_item_o)
  );

endmodule
